// File: sv/dsps_pkg.sv
package dsps_pkg;

    localparam int CAPACITY_DEF    = 64;
    localparam int COORD_WIDTH_DEF = 16;
    localparam int FIELD_WIDTH     = 16;
    localparam int INDEX_WIDTH     = 6;

    typedef enum logic [2:0] {
        CMD_INSERT       = 3'd0,
        CMD_REMOVE_FIRST = 3'd1,
        CMD_REMOVE_LAST  = 3'd2,
        CMD_REMOVE_AT    = 3'd3,
        CMD_DEDUP        = 3'd4
    } command_t;

    typedef enum logic [1:0] {
        STATUS_DONE  = 2'd0,
        STATUS_EMPTY = 2'd1,
        STATUS_FULL  = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE  = 2'd0,
        ST_KEY   = 2'd1,
        ST_EXEC  = 2'd2,
        ST_DEDUP = 2'd3
    } state_t;

    typedef enum logic [1:0] {
        OP_HOLD   = 2'd0,
        OP_INSERT = 2'd1,
        OP_REMOVE = 2'd2,
        OP_DEDUP  = 2'd3
    } cell_op_t;

    typedef struct packed {
        logic [2:0]             command;
        logic signed [15:0]     x_coord;
        logic signed [15:0]     y_coord;
        logic [INDEX_WIDTH-1:0] entry_index;
    } in_beat_t;

    typedef struct packed {
        logic [1:0]             status;
        logic signed [15:0]     point_x;
        logic signed [15:0]     point_y;
        logic [INDEX_WIDTH-1:0] removed_count;
    } out_beat_t;

endpackage

// File: sv/distance_sorted_point_store_top.sv
// Channel  | Ports                       | Beat marked by
// command  | start, busy, cmd_in         | start && !busy
// result   | done, result                | done (one cycle)
// Insert and removes pass from start to done through a key register stage
// after the squared-distance multipliers, then the cell update in EXEC.
// Delete duplicates stays in DEDUP until no duplicate is left; a cell row
// closes one gap per cycle. Reset empties the row at once by clearing valid
// bits. The receiver cannot stall; busy holds while an item is in work.
module distance_sorted_point_store_top #(
    parameter int CAPACITY    = dsps_pkg::CAPACITY_DEF,
    parameter int COORD_WIDTH = dsps_pkg::COORD_WIDTH_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  dsps_pkg::in_beat_t  cmd_in,
    output logic                done,
    output dsps_pkg::out_beat_t result
);

    localparam int CW = COORD_WIDTH;
    localparam int IW = dsps_pkg::INDEX_WIDTH;

    dsps_pkg::state_t     state_reg, state_next;
    dsps_pkg::in_beat_t   cmd_reg;
    logic [2*CW-1:0]      key_reg;
    logic signed [CW-1:0] nx, ny;
    logic signed [2*CW-1:0] sq_x, sq_y;
    logic [IW-1:0]        rcnt_reg, rcnt_next;
    logic                 done_reg, done_next;
    dsps_pkg::out_beat_t  res_reg, res_next;
    dsps_pkg::cell_op_t   op;
    logic [CAPACITY-1:0]  rm_sel, valid, dup;
    logic signed [CW-1:0] sel_x, sel_y;
    logic [CAPACITY-1:0]  last_one;

    assign nx = CW'(unsigned'(cmd_reg.x_coord));
    assign ny = CW'(unsigned'(cmd_reg.y_coord));
    assign sq_x = nx * nx;
    assign sq_y = ny * ny;
    assign last_one = valid & ~(valid >> 1);

    always_ff @(posedge clk)
    begin
        if (start && !busy)
            cmd_reg <= cmd_in;
        if (state_reg == dsps_pkg::ST_KEY)
            key_reg <= unsigned'(sq_x) + unsigned'(sq_y);
        res_reg <= res_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= dsps_pkg::ST_IDLE;
            done_reg  <= 1'b0;
            rcnt_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            rcnt_reg  <= rcnt_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        done_next  = 1'b0;
        rcnt_next  = rcnt_reg;
        res_next   = res_reg;
        op         = dsps_pkg::OP_HOLD;
        rm_sel     = '0;
        case (state_reg)
            dsps_pkg::ST_IDLE:
                if (start && !busy)
                    state_next = dsps_pkg::ST_KEY;
            dsps_pkg::ST_KEY:
            begin
                rcnt_next  = '0;
                state_next = (cmd_reg.command == dsps_pkg::CMD_DEDUP) ?
                             dsps_pkg::ST_DEDUP : dsps_pkg::ST_EXEC;
            end
            dsps_pkg::ST_EXEC:
            begin
                res_next   = '0;
                done_next  = 1'b1;
                state_next = dsps_pkg::ST_IDLE;
                case (cmd_reg.command)
                    dsps_pkg::CMD_INSERT:
                        if (valid[CAPACITY-1])
                            res_next.status = dsps_pkg::STATUS_FULL;
                        else
                            op = dsps_pkg::OP_INSERT;
                    dsps_pkg::CMD_REMOVE_FIRST:
                        rm_sel = CAPACITY'(valid[0]);
                    dsps_pkg::CMD_REMOVE_LAST:
                        rm_sel = last_one;
                    dsps_pkg::CMD_REMOVE_AT:
                        if (32'(cmd_reg.entry_index) < CAPACITY)
                            rm_sel = valid & (CAPACITY'(1) << cmd_reg.entry_index);
                    default:
                    begin
                    end
                endcase
                if (cmd_reg.command == dsps_pkg::CMD_REMOVE_FIRST
                    || cmd_reg.command == dsps_pkg::CMD_REMOVE_LAST
                    || cmd_reg.command == dsps_pkg::CMD_REMOVE_AT)
                begin
                    if (rm_sel == '0)
                        res_next.status = dsps_pkg::STATUS_EMPTY;
                    else
                    begin
                        op = dsps_pkg::OP_REMOVE;
                        res_next.point_x = 16'(sel_x);
                        res_next.point_y = 16'(sel_y);
                    end
                end
            end
            dsps_pkg::ST_DEDUP:
            begin
                if (dup != '0)
                begin
                    op        = dsps_pkg::OP_DEDUP;
                    rcnt_next = rcnt_reg + IW'(1);
                end
                else
                begin
                    res_next = '0;
                    res_next.removed_count = rcnt_reg;
                    done_next  = 1'b1;
                    state_next = dsps_pkg::ST_IDLE;
                end
            end
            default:
                state_next = dsps_pkg::ST_IDLE;
        endcase
    end

    dsps_chain #(.CAPACITY(CAPACITY), .CW(CW)) u_chain (
        .clk(clk), .rst_n(rst_n), .op(op),
        .new_key(key_reg), .new_x(nx), .new_y(ny),
        .rm_sel(rm_sel), .valid(valid), .dup(dup),
        .sel_x(sel_x), .sel_y(sel_y)
    );

    assign busy   = (state_reg != dsps_pkg::ST_IDLE) || done_reg;
    assign done   = done_reg;
    assign result = res_reg;

endmodule

// File: sv/dsps_cell.sv
module dsps_cell #(
    parameter int CW = dsps_pkg::COORD_WIDTH_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  dsps_pkg::cell_op_t     op,
    input  logic [2*CW-1:0]        new_key,
    input  logic signed [CW-1:0]   new_x,
    input  logic signed [CW-1:0]   new_y,
    input  logic                   ins_prev_after,
    input  logic                   prev_valid,
    input  logic [2*CW-1:0]        prev_key,
    input  logic signed [CW-1:0]   prev_x,
    input  logic signed [CW-1:0]   prev_y,
    input  logic                   next_valid,
    input  logic [2*CW-1:0]        next_key,
    input  logic signed [CW-1:0]   next_x,
    input  logic signed [CW-1:0]   next_y,
    input  logic                   rm_here,
    input  logic                   rm_before,
    output logic                   valid,
    output logic [2*CW-1:0]        key,
    output logic signed [CW-1:0]   px,
    output logic signed [CW-1:0]   py,
    output logic                   after_new,
    output logic                   dup_prev
);

    logic                 valid_reg, valid_next;
    logic [2*CW-1:0]      key_reg, key_next;
    logic signed [CW-1:0] x_reg, x_next, y_reg, y_next;

    always_comb
    begin
        if (key_reg != new_key)
            after_new = key_reg > new_key;
        else if (x_reg != new_x)
            after_new = x_reg > new_x;
        else
            after_new = y_reg > new_y;
        after_new = after_new && valid_reg;
        dup_prev = valid_reg && prev_valid && prev_x == x_reg && prev_y == y_reg;
    end

    always_comb
    begin
        valid_next = valid_reg;
        key_next   = key_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        case (op)
            dsps_pkg::OP_INSERT:
            begin
                if (ins_prev_after)
                begin
                    valid_next = prev_valid;
                    key_next   = prev_key;
                    x_next     = prev_x;
                    y_next     = prev_y;
                end
                else if (after_new || !valid_reg)
                begin
                    valid_next = 1'b1;
                    key_next   = new_key;
                    x_next     = new_x;
                    y_next     = new_y;
                end
            end
            dsps_pkg::OP_REMOVE, dsps_pkg::OP_DEDUP:
            begin
                if (rm_here || rm_before)
                begin
                    valid_next = next_valid;
                    key_next   = next_key;
                    x_next     = next_x;
                    y_next     = next_y;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
        x_reg   <= x_next;
        y_reg   <= y_next;
    end

    assign valid = valid_reg;
    assign key   = key_reg;
    assign px    = x_reg;
    assign py    = y_reg;

endmodule

// File: sv/dsps_chain.sv
module dsps_chain #(
    parameter int CAPACITY = dsps_pkg::CAPACITY_DEF,
    parameter int CW       = dsps_pkg::COORD_WIDTH_DEF
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  dsps_pkg::cell_op_t      op,
    input  logic [2*CW-1:0]         new_key,
    input  logic signed [CW-1:0]    new_x,
    input  logic signed [CW-1:0]    new_y,
    input  logic [CAPACITY-1:0]     rm_sel,
    output logic [CAPACITY-1:0]     valid,
    output logic [CAPACITY-1:0]     dup,
    output logic signed [CW-1:0]    sel_x,
    output logic signed [CW-1:0]    sel_y
);

    logic [2*CW-1:0]      key [CAPACITY];
    logic signed [CW-1:0] px  [CAPACITY];
    logic signed [CW-1:0] py  [CAPACITY];
    logic [CAPACITY-1:0]  after_new;
    logic [CAPACITY-1:0]  rm_here;
    logic [CAPACITY-1:0]  rm_before;

    // In a dedup pass only the lowest-indexed duplicate of the row leaves per cycle.
    always_comb
    begin
        rm_here = '0;
        if (op == dsps_pkg::OP_DEDUP)
        begin
            for (int i = 0; i < CAPACITY; i++)
                if (dup[i] && ((dup & ((CAPACITY'(1) << i) - CAPACITY'(1))) == '0))
                    rm_here[i] = 1'b1;
        end
        else
            rm_here = rm_sel;
        rm_before[0] = 1'b0;
        for (int i = 1; i < CAPACITY; i++)
            rm_before[i] = rm_before[i-1] | rm_here[i-1];
    end

    always_comb
    begin
        sel_x = '0;
        sel_y = '0;
        for (int i = 0; i < CAPACITY; i++)
            if (rm_sel[i])
            begin
                sel_x = px[i];
                sel_y = py[i];
            end
    end

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        localparam int P = (i == 0) ? 0 : i - 1;
        localparam int N = (i == CAPACITY - 1) ? i : i + 1;
        dsps_cell #(.CW(CW)) u_cell (
            .clk(clk), .rst_n(rst_n), .op(op),
            .new_key(new_key), .new_x(new_x), .new_y(new_y),
            .ins_prev_after((i != 0) && (after_new[P] || !valid[P])),
            .prev_valid((i != 0) && valid[P]),
            .prev_key(key[P]), .prev_x(px[P]), .prev_y(py[P]),
            .next_valid((i != CAPACITY - 1) && valid[N]),
            .next_key(key[N]), .next_x(px[N]), .next_y(py[N]),
            .rm_here(rm_here[i]), .rm_before(rm_before[i]),
            .valid(valid[i]), .key(key[i]), .px(px[i]), .py(py[i]),
            .after_new(after_new[i]), .dup_prev(dup[i])
        );
    end

endmodule

// File: sv/dsps_checker.sv
module dsps_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                start,
    input logic                busy,
    input logic                done,
    input dsps_pkg::out_beat_t result
);

    a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy) else $error("busy not raised after a beat");

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done) else $error("done held two cycles");

    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> result.status != 2'd3) else $error("bad status code");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.status != dsps_pkg::STATUS_DONE |-> result.point_x == 16'd0
            && result.point_y == 16'd0 && result.removed_count == '0)
        else $error("failed beat carries data");

endmodule

bind distance_sorted_point_store_top dsps_checker u_dsps_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .done(done), .result(result)
);
